>>> hw/rtl/msf_pkg.sv
// Shared types and constants of the media sync follower.
package msf_pkg;

  localparam int unsigned MSF_QDEPTH = 2;

  localparam logic [7:0] NEVER_ANNOUNCED = 8'hFF;
  localparam logic [7:0] PLAY_STOPPED    = 8'd0;
  localparam logic [7:0] PLAY_RUNNING    = 8'd1;

  localparam logic [1:0] CFG_DESYNC_THR = 2'd0;
  localparam logic [1:0] CFG_JUMP_THR   = 2'd1;
  localparam logic [1:0] CFG_RESEND_IVL = 2'd2;

  typedef enum logic [1:0] {
    EV_INDEX = 2'd0,
    EV_FRAME = 2'd1,
    EV_START = 2'd2,
    EV_STOP  = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [15:0] desync_thr;
    logic [15:0] jump_thr;
    logic [15:0] resend_ivl;
  } cfg_t;

  // One classified packet on its way from the front to the back.
  typedef struct packed {
    logic        coarse;
    logic        st_play;
    logic        st_stop;
    logic [7:0]  idx;
    logic [31:0] comp;
    logic [31:0] comp_rel;
    logic [31:0] now;
  } item_t;

endpackage

>>> hw/rtl/msf_front.sv
// Front part: takes packets, drops rejected ones and does the per-packet arithmetic.
module msf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  msf_pkg::cfg_t  cfg,
  input  logic           push,
  output logic           full,
  input  logic           in_long_enough,
  input  logic           in_layer_match,
  input  logic [7:0]     in_media_index,
  input  logic [7:0]     in_play_state,
  input  logic [31:0]    in_position_ms,
  input  logic [31:0]    in_sender_stamp_ms,
  input  logic [31:0]    in_mesh_now_ms,
  input  logic [31:0]    in_local_now_ms,
  output logic           q_push,
  input  logic           q_full,
  output msf_pkg::item_t q_item
);
  import msf_pkg::*;

  logic        f_valid_r, f_valid_nxt;
  logic [7:0]  f_idx_r;
  logic [7:0]  f_st_r;
  logic [31:0] f_pos_r;
  logic [31:0] f_stamp_r;
  logic [31:0] f_mesh_r;
  logic [31:0] f_now_r;

  logic        accept;
  logic [31:0] delta;
  logic [31:0] delta_bias;
  logic [31:0] thr2;
  logic        trusted;
  logic        st_play;
  logic        use_delta;
  logic [31:0] pos_d;
  logic [31:0] pos_d_rel;
  logic [31:0] pos_rel;

  assign accept = push && !full;
  assign full   = f_valid_r && q_full;
  assign q_push = f_valid_r && !q_full;

  always_comb begin
    if (accept) begin
      f_valid_nxt = in_long_enough && in_layer_match;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_idx_r   <= in_media_index;
      f_st_r    <= in_play_state;
      f_pos_r   <= in_position_ms;
      f_stamp_r <= in_sender_stamp_ms;
      f_mesh_r  <= in_mesh_now_ms;
      f_now_r   <= in_local_now_ms;
    end
  end

  // The clocks agree when the signed delta lies in [-thr, thr]; biasing by thr
  // turns that into one unsigned compare against 2*thr.
  assign delta      = f_mesh_r - f_stamp_r;
  assign delta_bias = f_mesh_r - f_stamp_r + {16'b0, cfg.desync_thr};
  assign thr2       = {15'b0, cfg.desync_thr, 1'b0};
  assign trusted    = delta_bias <= thr2;
  assign st_play    = f_st_r == PLAY_RUNNING;
  assign use_delta  = trusted && st_play && !delta[31];

  assign pos_d     = f_pos_r + f_mesh_r - f_stamp_r;
  assign pos_d_rel = f_pos_r + f_mesh_r - f_stamp_r - f_now_r;
  assign pos_rel   = f_pos_r - f_now_r;

  always_comb begin
    q_item.coarse   = !trusted;
    q_item.st_play  = st_play;
    q_item.st_stop  = f_st_r == PLAY_STOPPED;
    q_item.idx      = f_idx_r;
    q_item.comp     = use_delta ? pos_d : f_pos_r;
    q_item.comp_rel = use_delta ? pos_d_rel : pos_rel;
    q_item.now      = f_now_r;
  end

endmodule

>>> hw/rtl/msf_queue.sv
// Short queue of classified packets between the front and the back.
module msf_queue #(
  parameter int unsigned DEPTH = msf_pkg::MSF_QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  msf_pkg::item_t wr_item,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_empty,
  output msf_pkg::item_t rd_item
);
  import msf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = count_r == CW'(DEPTH);
  assign q_empty = count_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hw/rtl/msf_back.sv
// Back part: keeps the follower state, builds each packet's event list and emits it.
module msf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  msf_pkg::cfg_t  cfg,
  input  logic           q_empty,
  output logic           q_pop,
  input  msf_pkg::item_t q_item,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     out_event_kind,
  output logic [31:0]    out_event_value,
  output logic           out_coarse_follow,
  output logic           out_last_event
);
  import msf_pkg::*;

  // Follower state. Held position and clock anchor only matter while playing,
  // so they are kept as their difference.
  logic        held_play_r, held_play_nxt;
  logic        held_stop_r, held_stop_nxt;
  logic [31:0] base_r, base_nxt;
  logic [7:0]  ann_r, ann_nxt;
  logic [31:0] at_r, at_nxt;

  // Event list of the packet being emitted.
  ev_kind_t    lk_r [3];
  logic [31:0] lv_r [3];
  logic        lcoarse_r;
  logic [1:0]  lcnt_r, lcnt_nxt;
  logic [1:0]  lptr_r, lptr_nxt;

  logic        out_valid_r, out_valid_nxt;
  ev_kind_t    out_kind_r;
  logic [31:0] out_val_r;
  logic        out_coarse_r;
  logic        out_last_r;

  ev_kind_t    nk [3];
  logic [31:0] nv [3];
  logic [1:0]  nn;

  logic        out_free;
  logic        have;
  logic        on_last;
  logic        move;
  logic        sel_idx;
  logic        jumped;
  logic        to_playing;
  logic        to_stopped;
  logic        first_stopped;
  logic        resend;
  logic [31:0] jump_bias;
  logic [31:0] since_ann;

  assign out_free = !out_valid_r || pop;
  assign have     = lptr_r != lcnt_r;
  assign on_last  = (lptr_r + 2'd1) == lcnt_r;
  assign move     = have && out_free;
  assign q_pop    = !q_empty && (!have || (on_last && out_free));

  assign sel_idx       = (ann_r != q_item.idx) && (q_item.idx != '0);
  assign jump_bias     = q_item.comp_rel - base_r + {16'b0, cfg.jump_thr};
  assign jumped        = held_play_r && q_item.st_play &&
                         (jump_bias > {15'b0, cfg.jump_thr, 1'b0});
  assign to_playing    = held_stop_r && q_item.st_play;
  assign to_stopped    = held_play_r && q_item.st_stop;
  assign first_stopped = (ann_r == NEVER_ANNOUNCED) && q_item.st_stop && (q_item.idx == '0);
  assign since_ann     = q_item.now - at_r;
  // A fresh index select sets the announce time to now, which rules out a resend.
  assign resend        = !sel_idx && (cfg.resend_ivl != '0) && q_item.st_play &&
                         (q_item.idx != '0) && (since_ann >= {16'b0, cfg.resend_ivl});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nk[i] = EV_INDEX;
      nv[i] = '0;
    end
    nn = '0;
    if (sel_idx) begin
      nk[nn] = EV_INDEX;
      nv[nn] = {24'b0, q_item.idx};
      nn     = nn + 2'd1;
    end
    if (jumped) begin
      nk[nn] = EV_FRAME;
      nv[nn] = q_item.comp;
      nn     = nn + 2'd1;
    end
    if (to_playing) begin
      nk[nn] = EV_FRAME;
      nv[nn] = q_item.comp;
      nn     = nn + 2'd1;
      nk[nn] = EV_START;
      nv[nn] = '0;
      nn     = nn + 2'd1;
    end else if (to_stopped || first_stopped) begin
      nk[nn] = EV_INDEX;
      nv[nn] = '0;
      nn     = nn + 2'd1;
      nk[nn] = EV_STOP;
      nv[nn] = '0;
      nn     = nn + 2'd1;
    end else if (resend) begin
      nk[nn] = EV_INDEX;
      nv[nn] = {24'b0, q_item.idx};
      nn     = nn + 2'd1;
    end
  end

  always_comb begin
    held_play_nxt = held_play_r;
    held_stop_nxt = held_stop_r;
    base_nxt      = base_r;
    ann_nxt       = ann_r;
    at_nxt        = at_r;
    lcnt_nxt      = lcnt_r;
    lptr_nxt      = move ? lptr_r + 2'd1 : lptr_r;
    if (q_pop) begin
      held_play_nxt = q_item.st_play;
      held_stop_nxt = q_item.st_stop;
      if (q_item.st_play) begin
        base_nxt = q_item.comp_rel;
      end
      if (sel_idx) begin
        ann_nxt = q_item.idx;
        at_nxt  = q_item.now;
      end
      if (!to_playing && (to_stopped || first_stopped)) begin
        ann_nxt = '0;
        at_nxt  = q_item.now;
      end else if (!to_playing && resend) begin
        at_nxt = q_item.now;
      end
      lcnt_nxt = nn;
      lptr_nxt = '0;
    end
  end

  always_comb begin
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_play_r <= 1'b0;
      held_stop_r <= 1'b1;
      ann_r       <= NEVER_ANNOUNCED;
      at_r        <= '0;
      lcnt_r      <= '0;
      lptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_play_r <= held_play_nxt;
      held_stop_r <= held_stop_nxt;
      ann_r       <= ann_nxt;
      at_r        <= at_nxt;
      lcnt_r      <= lcnt_nxt;
      lptr_r      <= lptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    if (q_pop) begin
      lk_r      <= nk;
      lv_r      <= nv;
      lcoarse_r <= q_item.coarse;
    end
    if (move) begin
      out_kind_r   <= lk_r[lptr_r];
      out_val_r    <= lv_r[lptr_r];
      out_coarse_r <= lcoarse_r;
      out_last_r   <= on_last;
    end
  end

  assign empty             = !out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_event_value   = out_val_r;
  assign out_coarse_follow = out_coarse_r;
  assign out_last_event    = out_last_r;

endmodule

>>> hw/rtl/media_sync_follower_unit.sv
// Media sync follower: takes media-sync packets from a master and returns the events
// they cause (index select, full frame, start, stop), each packet's events in order with
// the last one flagged. A packet causes one to three events or none; its events leave the event
// stage one after another, and a packet that causes no event still passes through that stage;
// packets that are too short or for another layer are dropped at the input and never reach it.
// The single event output register emits one event per cycle while pop keeps taking them.
// A packet passes through the input register, the packet queue, the event list and the
// output register. Configuration registers may be written only while idle.
module media_sync_follower_unit #(
  parameter int unsigned QUEUE_DEPTH = msf_pkg::MSF_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_long_enough,
  input  logic        in_layer_match,
  input  logic [7:0]  in_media_index,
  input  logic [7:0]  in_play_state,
  input  logic [31:0] in_position_ms,
  input  logic [31:0] in_sender_stamp_ms,
  input  logic [31:0] in_mesh_now_ms,
  input  logic [31:0] in_local_now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_event_value,
  output logic        out_coarse_follow,
  output logic        out_last_event,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import msf_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t f_item;
  item_t b_item;
  logic  f_push;
  logic  q_full;
  logic  q_empty;
  logic  b_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DESYNC_THR: cfg_nxt.desync_thr = cfg_wdata;
        CFG_JUMP_THR:   cfg_nxt.jump_thr   = cfg_wdata;
        CFG_RESEND_IVL: cfg_nxt.resend_ivl = cfg_wdata;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.desync_thr <= 16'd200;
      cfg_r.jump_thr   <= 16'd500;
      cfg_r.resend_ivl <= 16'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .push               (push),
    .full               (full),
    .in_long_enough     (in_long_enough),
    .in_layer_match     (in_layer_match),
    .in_media_index     (in_media_index),
    .in_play_state      (in_play_state),
    .in_position_ms     (in_position_ms),
    .in_sender_stamp_ms (in_sender_stamp_ms),
    .in_mesh_now_ms     (in_mesh_now_ms),
    .in_local_now_ms    (in_local_now_ms),
    .q_push             (f_push),
    .q_full             (q_full),
    .q_item             (f_item)
  );

  msf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_item (f_item),
    .q_full  (q_full),
    .rd_en   (b_pop),
    .q_empty (q_empty),
    .rd_item (b_item)
  );

  msf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_pop             (b_pop),
    .q_item            (b_item),
    .empty             (empty),
    .pop               (pop),
    .out_event_kind    (out_event_kind),
    .out_event_value   (out_event_value),
    .out_coarse_follow (out_coarse_follow),
    .out_last_event    (out_last_event)
  );

endmodule
